@@ rtl/kfi_pkg.sv @@
// Package for the keyframe interpolator: operation and status codes,
// register indexes, stream layout widths and the keyframe row type.
// No dependencies.
package kfi_pkg;

   // operation carried in req_tuser
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // status codes of a result item
   localparam logic [1:0] ST_ALIVE    = 2'd0;
   localparam logic [1:0] ST_FINISHED = 2'd1;
   localparam logic [1:0] ST_BACK_ERR = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_KEY_COUNT = 2'd0;
   localparam logic [1:0] CSR_LOOPING   = 2'd1;
   localparam logic [1:0] CSR_END_TIME  = 2'd2;

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 31;
   localparam int ReqDataW = 296;
   localparam int RspDataW = 232;
   localparam int CfBits   = 24;

   // one keyframe: pose words in output order, time in the lowest bits
   // val[0] pos_x, [1] pos_y, [2] pos_z, [3] angle, [4..6] axis_x/y/z
   typedef struct packed {
      logic [6:0][31:0] val;
      logic [30:0]      tm;
   } key_row_type;

endpackage

@@ rtl/keyframe_interpolator.sv @@
// Keyframe interpolator: a keyframe table in one synchronous memory,
// a cursor walk, a shared shift-subtract divider and a blend multiplier.
// Depends on kfi_pkg.
//
// A load item writes one table row in its accept cycle and gives no result.
// A query item is set up first; when looping mode must wrap the time into
// the span, the shared divider reduces it. The cursor then walks over the
// keyframes, one memory read each (bounded by the saturated key count + 2
// steps), and a blend fetches the second row, prepares, runs the coefficient
// division (one quotient bit a cycle) and forms the four blended values
// (one multiply and one round-and-saturate each). An exact keyframe skips
// the division and the blend. The result sits in an output register, so the
// next item is taken while it waits. No item is taken while a query is in
// progress.
module keyframe_interpolator #(
   parameter int KEY_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // key_index, key_time, key_pos_x/y/z, key_angle, key_axis_x/y/z, query_time
   input  logic [kfi_pkg::ReqDataW-1:0]   req_tdata,
   // operation
   input  logic                           req_tuser,
   // result items
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_pos_x/y/z, out_angle, out_axis_x/y/z, status
   output logic [kfi_pkg::RspDataW-1:0]   rsp_tdata,
   // configuration writes
   input  logic                           csr_we,
   input  logic [kfi_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [kfi_pkg::CsrDataW-1:0]   csr_wdata
);
   import kfi_pkg::*;

   localparam int IW = (KEY_DEPTH > 2) ? $clog2(KEY_DEPTH) : 1;
   localparam int CW = (IW + 1 > 9) ? IW + 1 : 9;
   localparam int SW = IW + 2;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_REDUCE = 13'b0000000000010,
      S_START  = 13'b0000000000100,
      S_CHECK  = 13'b0000000001000,
      S_STEP   = 13'b0000000010000,
      S_NBR    = 13'b0000000100000,
      S_LOADS  = 13'b0000001000000,
      S_PREP   = 13'b0000010000000,
      S_DIV    = 13'b0000100000000,
      S_MUL    = 13'b0001000000000,
      S_ACC    = 13'b0010000000000,
      S_EMIT   = 13'b0100000000000,
      S_FIN    = 13'b1000000000000
   } state_type;

   // configuration
   logic [8:0]  kc_ff;
   logic        lp_ff;
   logic [30:0] end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kc_ff  <= 9'd1;
         lp_ff  <= 1'b0;
         end_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_COUNT: kc_ff  <= csr_wdata[8:0];
            CSR_LOOPING:   lp_ff  <= csr_wdata[0];
            CSR_END_TIME:  end_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // keys in use, saturated into 1..KEY_DEPTH
   logic [CW-1:0] kc_ext;
   logic [IW:0]   n_keys;
   logic [IW-1:0] last;

   always_comb begin
      kc_ext = CW'(kc_ff);
      if (kc_ff == 9'd0)
         n_keys = (IW+1)'(1);
      else if (kc_ext > CW'(KEY_DEPTH))
         n_keys = (IW+1)'(KEY_DEPTH);
      else
         n_keys = kc_ext[IW:0];
      last = IW'(n_keys - (IW+1)'(1));
   end

   // keyframe memory
   key_row_type mem [KEY_DEPTH];
   key_row_type rdata_ff;
   key_row_type wrow;
   logic        mem_we;
   logic [IW-1:0] raddr;

   assign wrow.tm  = req_tdata[38:8];
   assign wrow.val = req_tdata[262:39];

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[IW'(req_tdata[7:0])] <= wrow;
      rdata_ff <= mem[raddr];
   end

   // control and datapath registers
   state_type          state_ff, state_in;
   logic [IW-1:0]      c_ff, c_in, cursor_ff, cursor_in;
   logic [SW-1:0]      steps_ff, steps_in;
   logic signed [31:0] t_ff, t_in;
   logic               fwd_ff, fwd_in;
   logic               rneg_ff, rneg_in;
   key_row_type        orow_ff, orow_in, srow_ff, srow_in;
   logic signed [32:0] den_ff, den_in;
   logic signed [33:0] num_ff, num_in;
   logic [30:0]        dden_ff, dden_in;
   logic [30:0]        rem_ff, rem_in;
   logic [31:0]        dvd_ff, dvd_in;
   logic [23:0]        quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [24:0]        coeff_ff, coeff_in;
   logic [1:0]         ch_ff, ch_in;
   logic signed [58:0] prod_ff, prod_in;
   logic [6:0][31:0]   res_val_ff, res_val_in;
   logic [1:0]         res_st_ff, res_st_in;
   logic [6:0][31:0]   out_val_ff, out_val_in;
   logic [1:0]         out_st_ff, out_st_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic signed [31:0] qt;
   logic [31:0]        dv_tr;
   logic               dv_ge;
   logic [30:0]        dv_nrem;
   logic [IW-1:0]      c_start, c_nb;
   logic signed [31:0] row_t;
   logic signed [32:0] dn;
   logic signed [33:0] nm;
   logic signed [32:0] diff;
   logic signed [25:0] cf_s;
   logic signed [58:0] acc_sum;
   logic signed [34:0] blend_r;
   logic [31:0]        va, vb;

   assign qt    = $signed(req_tdata[294:263]);
   assign row_t = $signed({1'b0, rdata_ff.tm});

   // one restoring division step
   always_comb begin
      dv_tr   = {rem_ff, dvd_ff[31]};
      dv_ge   = dv_tr >= {1'b0, dden_ff};
      dv_nrem = dv_ge ? 31'(dv_tr - {1'b0, dden_ff}) : dv_tr[30:0];
   end

   assign c_start = (cursor_ff > last) ? last : cursor_ff;
   assign va      = srow_ff.val[ch_ff];
   assign vb      = orow_ff.val[ch_ff];

   always_comb begin
      diff    = $signed({vb[31], vb}) - $signed({va[31], va});
      cf_s    = $signed({1'b0, coeff_ff});
      acc_sum = prod_ff + 59'sd8388608;
      blend_r = $signed({{3{va[31]}}, va}) + $signed(acc_sum[58:24]);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_st_ff, out_val_ff};

   always_comb begin
      state_in     = state_ff;
      c_in         = c_ff;
      cursor_in    = cursor_ff;
      steps_in     = steps_ff;
      t_in         = t_ff;
      fwd_in       = fwd_ff;
      rneg_in      = rneg_ff;
      orow_in      = orow_ff;
      srow_in      = srow_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      dden_in      = dden_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      coeff_in     = coeff_ff;
      ch_in        = ch_ff;
      prod_in      = prod_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      out_val_in   = out_val_ff;
      out_st_in    = out_st_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      raddr        = '0;
      c_nb         = '0;
      dn           = '0;
      nm           = '0;

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_LOAD) begin
                  mem_we = (32'(req_tdata[7:0]) < 32'(KEY_DEPTH));
               end else begin
                  t_in     = qt;
                  state_in = S_START;
                  rem_in   = '0;
                  cnt_in   = '0;
                  dden_in  = end_ff;
                  if (lp_ff) begin
                     if (end_ff == '0) begin
                        t_in = '0;
                     end else if (qt > $signed({1'b0, end_ff})) begin
                        dvd_in   = 32'(qt - 32'sd1);
                        rneg_in  = 1'b0;
                        state_in = S_REDUCE;
                     end else if (qt < 0) begin
                        dvd_in   = 32'(-qt);
                        rneg_in  = 1'b1;
                        state_in = S_REDUCE;
                     end
                  end
               end
            end
         end

         // wrap the time into the span, one remainder bit a cycle
         S_REDUCE: begin
            rem_in = dv_nrem;
            dvd_in = {dvd_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (rneg_ff)
                  t_in = (dv_nrem != '0) ? $signed({1'b0, end_ff - dv_nrem}) : 32'sd0;
               else
                  t_in = $signed({1'b0, dv_nrem}) + 32'sd1;
               state_in = S_START;
            end
         end

         S_START: begin
            steps_in = '0;
            if (lp_ff && last == '0) begin
               c_in      = '0;
               raddr     = '0;
               res_st_in = ST_ALIVE;
               state_in  = S_EMIT;
            end else begin
               c_in     = c_start;
               raddr    = c_start;
               state_in = S_CHECK;
            end
         end

         // compare the time under the cursor
         S_CHECK: begin
            if (row_t == t_ff) begin
               res_val_in = rdata_ff.val;
               res_st_in  = (lp_ff || c_ff != last) ? ST_ALIVE : ST_FINISHED;
               cursor_in  = c_ff;
               state_in   = S_FIN;
            end else if (row_t < t_ff) begin
               fwd_in   = 1'b1;
               state_in = S_STEP;
               if (c_ff == last) begin
                  if (!lp_ff) begin
                     res_val_in = '0;
                     res_st_in  = ST_FINISHED;
                     cursor_in  = c_ff;
                     state_in   = S_FIN;
                  end else begin
                     c_in = '0;
                  end
               end
            end else begin
               fwd_in   = 1'b0;
               state_in = S_STEP;
            end
         end

         // issue the neighbour read, stop an endless walk or flag a back error
         S_STEP: begin
            if (steps_ff > {1'b0, n_keys}) begin
               raddr     = c_ff;
               res_st_in = ST_ALIVE;
               state_in  = S_EMIT;
            end else if (fwd_ff) begin
               raddr    = IW'(c_ff + 1'b1);
               state_in = S_NBR;
            end else if (c_ff == '0 && !lp_ff) begin
               res_val_in = '0;
               res_st_in  = ST_BACK_ERR;
               cursor_in  = '0;
               state_in   = S_FIN;
            end else begin
               c_nb     = (c_ff == '0) ? last : c_ff;
               c_in     = c_nb;
               raddr    = IW'(c_nb - 1'b1);
               state_in = S_NBR;
            end
         end

         // compare the neighbour time and advance, answer or blend
         S_NBR: begin
            c_nb = fwd_ff ? IW'(c_ff + 1'b1) : IW'(c_ff - 1'b1);
            if (fwd_ff ? (row_t < t_ff) : (row_t > t_ff)) begin
               steps_in = steps_ff + SW'(1);
               c_in     = c_nb;
               state_in = S_STEP;
               if (fwd_ff ? (c_nb == last) : (c_nb == '0)) begin
                  if (!lp_ff) begin
                     res_val_in = '0;
                     res_st_in  = ST_FINISHED;
                     cursor_in  = c_nb;
                     state_in   = S_FIN;
                  end else begin
                     c_in = fwd_ff ? '0 : last;
                  end
               end
            end else if (row_t == t_ff) begin
               res_val_in = rdata_ff.val;
               res_st_in  = (lp_ff || c_nb != last) ? ST_ALIVE : ST_FINISHED;
               cursor_in  = c_nb;
               state_in   = S_FIN;
            end else begin
               orow_in  = rdata_ff;
               raddr    = c_ff;
               state_in = S_LOADS;
            end
         end

         // start row: raw numerator and denominator; equal times answer at once
         S_LOADS: begin
            srow_in = rdata_ff;
            den_in  = $signed({2'b0, orow_ff.tm}) - $signed({2'b0, rdata_ff.tm});
            num_in  = $signed({{2{t_ff[31]}}, t_ff}) - $signed({3'b0, rdata_ff.tm});
            if (rdata_ff.tm == orow_ff.tm) begin
               res_val_in = rdata_ff.val;
               res_st_in  = (lp_ff || c_ff != last) ? ST_ALIVE : ST_FINISHED;
               cursor_in  = c_ff;
               state_in   = S_FIN;
            end else begin
               state_in = S_PREP;
            end
         end

         // fold the sign and clamp the numerator to [0, den]
         S_PREP: begin
            dn = den_ff;
            nm = num_ff;
            if (den_ff < 0) begin
               dn = -den_ff;
               nm = -num_ff;
            end
            if (nm < 0)
               nm = '0;
            if (nm > 34'(dn))
               nm = 34'(dn);
            dden_in = dn[30:0];
            rem_in  = nm[30:0];
            dvd_in  = '0;
            cnt_in  = '0;
            ch_in   = '0;
            if (nm == 34'(dn)) begin
               coeff_in = 25'(1) << CfBits;
               state_in = S_MUL;
            end else begin
               state_in = S_DIV;
            end
         end

         // coefficient fraction, one bit a cycle
         S_DIV: begin
            rem_in = dv_nrem;
            quo_in = {quo_ff[22:0], dv_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CfBits - 1)) begin
               coeff_in = {1'b0, quo_ff[22:0], dv_ge};
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            prod_in  = diff * cf_s;
            state_in = S_ACC;
         end

         // round half up, add the start value, saturate
         S_ACC: begin
            if (blend_r > 35'sd2147483647)
               res_val_in[ch_ff] = 32'h7FFFFFFF;
            else if (blend_r < -35'sd2147483648)
               res_val_in[ch_ff] = 32'h80000000;
            else
               res_val_in[ch_ff] = blend_r[31:0];
            ch_in    = ch_ff + 2'd1;
            state_in = S_MUL;
            if (ch_ff == 2'd3) begin
               res_val_in[4] = srow_ff.val[4];
               res_val_in[5] = srow_ff.val[5];
               res_val_in[6] = srow_ff.val[6];
               res_st_in     = (lp_ff || c_ff != last) ? ST_ALIVE : ST_FINISHED;
               cursor_in     = c_ff;
               state_in      = S_FIN;
            end
         end

         S_EMIT: begin
            res_val_in = rdata_ff.val;
            cursor_in  = c_ff;
            state_in   = S_FIN;
         end

         // hand the result to the output register once it is free
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_val_in   = res_val_ff;
               out_st_in    = res_st_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff       <= c_in;
      steps_ff   <= steps_in;
      t_ff       <= t_in;
      fwd_ff     <= fwd_in;
      rneg_ff    <= rneg_in;
      orow_ff    <= orow_in;
      srow_ff    <= srow_in;
      den_ff     <= den_in;
      num_ff     <= num_in;
      dden_ff    <= dden_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      coeff_ff   <= coeff_in;
      ch_ff      <= ch_in;
      prod_ff    <= prod_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      out_val_ff <= out_val_in;
      out_st_ff  <= out_st_in;
   end

endmodule

@@ rtl/kfi_checker.sv @@
// Port-level checks for the keyframe interpolator, bound to its top level.
// Depends on kfi_pkg and keyframe_interpolator.
module kfi_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [kfi_pkg::ReqDataW-1:0]   req_tdata,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [kfi_pkg::RspDataW-1:0]   rsp_tdata,
   input logic                           csr_we,
   input logic [kfi_pkg::CsrIdxW-1:0]    csr_index,
   input logic [kfi_pkg::CsrDataW-1:0]   csr_wdata
);
   import kfi_pkg::*;

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item valid after reset");

   // a stalled result item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // a load never brings a fresh result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_LOAD |=> !$rose(rsp_tvalid))
      else $error("result item after a load item");

   // status codes stay in range and an error carries a zero pose
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[225:224] == ST_ALIVE || rsp_tdata[225:224] == ST_FINISHED
         || (rsp_tdata[225:224] == ST_BACK_ERR && rsp_tdata[223:0] == '0))
      else $error("bad status or pose in result item");

endmodule

bind keyframe_interpolator kfi_checker u_kfi_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for keyframe_interpolator: a directed table, then random phases
// of load and query items. Poses are checked against a predictor in this file or, for
// some directed rows, a preset pose. Depends on kfi_pkg and keyframe_interpolator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kfi_pkg::*;

   localparam int      DEPTH      = 256;
   localparam longint  CYCLE_CAP  = 4000000;
   localparam int      ITEM_GOAL  = 1850;

   typedef struct packed {
      logic [6:0][31:0] val;
      logic [1:0]       st;
   } pose_t;

   typedef enum {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_e;

   typedef struct {
      row_kind_e        kind;
      int unsigned      idx;
      int unsigned      ktm;
      logic [6:0][31:0] val;
      logic [31:0]      qtm;
      int unsigned      kc;
      bit               lp;
      int unsigned      et;
      bit               typed;
      pose_t            want;
   } row_t;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   keyframe_interpolator u_top (.*);

   // keyframe table as the block should hold it
   longint           kf_time [DEPTH];
   logic [6:0][31:0] kf_val  [DEPTH];
   bit               kf_written [DEPTH];
   int unsigned      kf_cursor;
   int unsigned      cf_key_count;
   bit               cf_looping;
   longint           cf_end_time;

   pose_t  pose_queue[$];
   int     errors;
   int     items_sent;
   int     queries_sent;
   int     poses_seen;
   longint cycles;
   bit     calm;
   bit     hold_req;
   row_t   plan[$];

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic longint sat_blend(logic [31:0] a, logic [31:0] b, longint coeff);
      longint va, vb, r;
      va = longint'(signed'(a));
      vb = longint'(signed'(b));
      r = va + (((vb - va) * coeff + (64'sd1 <<< (CfBits - 1))) >>> CfBits);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   function automatic pose_t key_pose(int unsigned i);
      pose_t p;
      p.val = kf_val[i];
      p.st = ST_ALIVE;
      return p;
   endfunction

   // blend between keyframe a and its neighbour b; axis always from a
   function automatic pose_t blend_pose(int unsigned a, int unsigned b, longint t);
      pose_t  p;
      longint num, den, coeff, r;
      p = key_pose(a);
      if (kf_time[a] == kf_time[b]) return p;
      den = kf_time[b] - kf_time[a];
      num = t - kf_time[a];
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num < 0) num = 0;
      if (num > den) num = den;
      coeff = (num <<< CfBits) / den;
      for (int k = 0; k < 4; k++) begin
         r = sat_blend(kf_val[a][k], kf_val[b][k], coeff);
         p.val[k] = r[31:0];
      end
      return p;
   endfunction

   // pose for one query; advances the cursor as the block should
   function automatic pose_t interp_pose(logic [31:0] qraw);
      pose_t       p;
      int unsigned n, last, c, steps;
      longint      t, e, r;
      bit          lp;
      p = '0;
      lp = cf_looping;
      n = cf_key_count;
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      last = n - 1;
      t = longint'(signed'(qraw));
      if (lp) begin
         e = cf_end_time;
         if (e == 0) t = 0;
         else if (t > e) t = ((t - 1) % e) + 1;
         else if (t < 0) begin
            r = (-t) % e;
            t = (r != 0) ? e - r : 0;
         end
      end
      c = kf_cursor;
      if (c > last) c = last;
      if (lp && last == 0) begin
         kf_cursor = 0;
         return key_pose(0);
      end
      steps = 0;
      if (kf_time[c] < t) begin
         // walk forward
         if (c == last) begin
            if (!lp) begin
               kf_cursor = c;
               p.st = ST_FINISHED;
               return p;
            end
            c = 0;
         end
         forever begin
            if (steps > n) begin
               kf_cursor = c;
               return key_pose(c);
            end
            steps++;
            if (kf_time[c+1] < t) begin
               c++;
               if (c == last) begin
                  if (!lp) begin
                     kf_cursor = c;
                     p.st = ST_FINISHED;
                     return p;
                  end
                  c = 0;
               end
               continue;
            end
            if (kf_time[c+1] == t) begin
               c++;
               p = key_pose(c);
            end else p = blend_pose(c, c + 1, t);
            break;
         end
      end else if (kf_time[c] == t) begin
         p = key_pose(c);
      end else begin
         // walk backward
         forever begin
            if (steps > n) begin
               kf_cursor = c;
               return key_pose(c);
            end
            steps++;
            if (c == 0) begin
               if (!lp) begin
                  kf_cursor = 0;
                  p.st = ST_BACK_ERR;
                  return p;
               end
               c = last;
            end
            if (kf_time[c-1] > t) begin
               c--;
               if (c == 0) begin
                  if (!lp) begin
                     kf_cursor = c;
                     p = '0;
                     p.st = ST_FINISHED;
                     return p;
                  end
                  c = last;
               end
               continue;
            end
            if (kf_time[c-1] == t) begin
               c--;
               p = key_pose(c);
            end else p = blend_pose(c, c - 1, t);
            break;
         end
      end
      kf_cursor = c;
      p.st = (lp || c != last) ? ST_ALIVE : ST_FINISHED;
      return p;
   endfunction

   // result side: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_req) begin
         rsp_tready <= 1'b0;
         repeat (400) @(posedge clock);
         hold_req = 1'b0;
      end else rsp_tready <= calm || ($urandom_range(0, 99) >= 24);
   end

   // compare each accepted pose with the oldest expectation
   always @(posedge clock) begin
      pose_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         for (int k = 0; k < 7; k++) got.val[k] = rsp_tdata[32*k +: 32];
         got.st = rsp_tdata[225:224];
         poses_seen++;
         if (pose_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected pose %h", got);
         end else begin
            want = pose_queue.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("pose mismatch: exp st %0d val %h / got st %0d val %h",
                           want.st, want.val, got.st, got.val);
            end
         end
      end
   end

   task automatic random_gap();
      if (!calm && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // offer one item, wait for it to be taken, then update the predictor
   task automatic send_item(bit op, int unsigned idx, int unsigned ktm,
                            logic [6:0][31:0] val, logic [31:0] qtm,
                            bit typed, pose_t want);
      pose_t p;
      random_gap();
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, qtm, val, ktm[30:0], idx[7:0]};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == OP_LOAD) begin
         kf_time[idx[7:0]] = ktm[30:0];
         kf_val[idx[7:0]] = val;
         kf_written[idx[7:0]] = 1'b1;
      end else begin
         queries_sent++;
         p = interp_pose(qtm);
         pose_queue.push_back(typed ? want : p);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_regs(int unsigned kc, bit lp, int unsigned et);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_KEY_COUNT;
      csr_wdata <= kc & 9'h1FF;
      @(posedge clock);
      csr_index <= CSR_LOOPING;
      csr_wdata <= lp;
      @(posedge clock);
      csr_index <= CSR_END_TIME;
      csr_wdata <= et[30:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cf_key_count = kc & 9'h1FF;
      cf_looping = lp;
      cf_end_time = et & 32'h7FFF_FFFF;
   endtask

   function automatic logic [6:0][31:0] random_vals();
      logic [6:0][31:0] v;
      for (int k = 0; k < 7; k++) v[k] = $urandom;
      return v;
   endfunction

   task automatic add_row(row_kind_e kind, int unsigned a, int unsigned b,
                          logic [6:0][31:0] val, logic [31:0] qtm, bit typed, pose_t want);
      row_t r;
      r.kind = kind;
      r.idx = a;
      r.ktm = b;
      r.kc = a;
      r.lp = b[0];
      r.et = qtm;
      r.val = val;
      r.qtm = qtm;
      r.typed = typed;
      r.want = want;
      plan.push_back(r);
   endtask

   initial begin
      logic [6:0][31:0] top_v, bot_v;
      pose_t            z, w;
      row_t             r;
      int unsigned      n, last, step, t0, kc, et, lt, nq, phase;
      bit               lp;
      longint           q;

      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_LOAD;
      csr_we     <= 1'b0;
      csr_index  <= CSR_KEY_COUNT;
      csr_wdata  <= '0;
      cycles = 0;
      calm = 0;
      hold_req = 0;
      kf_cursor = 0;
      cf_key_count = 1;
      cf_looping = 0;
      cf_end_time = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: extremes, equal times, errors, wrap cases
      for (int k = 0; k < 7; k++) begin
         top_v[k] = 32'h7FFF_FFFF;
         bot_v[k] = 32'h8000_0000;
      end
      z = '0;
      add_row(ROW_LOAD, 0, 0, top_v, 0, 0, z);
      w = z; w.st = ST_BACK_ERR;
      add_row(ROW_QUERY, 0, 0, '0, 32'hFFFF_FFFF, 1, w);
      w.val = top_v; w.st = ST_FINISHED;
      add_row(ROW_QUERY, 0, 0, '0, 32'h0, 1, w);
      w = z; w.st = ST_FINISHED;
      add_row(ROW_QUERY, 0, 0, '0, 32'h5, 1, w);
      add_row(ROW_CFG, 4, 0, '0, 0, 0, z);
      add_row(ROW_LOAD, 1, 32'h10000, bot_v, 0, 0, z);
      add_row(ROW_LOAD, 2, 32'h10000, random_vals(), 0, 0, z);
      add_row(ROW_LOAD, 3, 32'h7FFF_FFFF, top_v, 0, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h8000, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h10000, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h20000, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h7FFF_FFFF, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'hFFFF_FFFB, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h4000_0000, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h8000, 0, z);
      add_row(ROW_CFG, 4, 1, '0, 32'h30000, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h7FFF_FFFF, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h8000_0000, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h30000, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h12345, 0, z);
      add_row(ROW_CFG, 4, 1, '0, 32'h0, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h12345, 0, z);
      add_row(ROW_CFG, 0, 1, '0, 32'h7FFF_FFFF, 0, z);
      add_row(ROW_QUERY, 0, 0, '0, 32'h9999, 0, z);
      foreach (plan[i]) begin
         r = plan[i];
         if (r.kind == ROW_CFG) write_regs(r.kc, r.lp, r.et);
         else send_item(r.kind == ROW_QUERY ? OP_QUERY : OP_LOAD, r.idx, r.ktm,
                        r.val, r.qtm, r.typed, r.want);
      end

      // random phases: new settings, refreshed table, then mostly queries
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         phase++;
         if (phase == 3) kc = 256;
         else if (phase == 9) kc = $urandom_range(257, 511);
         else case ($urandom_range(0, 9))
            0:       kc = 0;
            1:       kc = 1;
            default: kc = $urandom_range(2, 12);
         endcase
         n = (kc == 0) ? 1 : (kc > DEPTH ? DEPTH : kc);
         last = n - 1;
         step = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 32'h4000)
                                            : $urandom_range(1, 32'h7FFF_FFFF / (n + 2));
         t0 = $urandom_range(0, step);
         // mostly rising times; some phases equal or unordered
         for (int i = 0; i < n; i++) begin
            if (!kf_written[i] || $urandom_range(0, 9) < 8 || n > 12) begin
               case (phase % 7)
                  5:       lt = $urandom & 32'h7FFF_FFFF;
                  6:       lt = t0 + (i / 2) * step;
                  default: lt = t0 + i * step + $urandom_range(0, step - 1);
               endcase
               send_item(OP_LOAD, i, lt, random_vals(), 0, 0, z);
            end
         end
         drain();
         lt = kf_time[last];
         lp = $urandom_range(0, 1);
         case ($urandom_range(0, 4))
            0:       et = 0;
            1:       et = lt;
            2:       et = lt + $urandom_range(0, 16);
            3:       et = $urandom_range(lt / 2, lt);
            default: et = 32'h7FFF_FFFF;
         endcase
         write_regs(kc, lp, et);
         calm = (phase == 5);
         if (phase == 2) hold_req = 1'b1;
         nq = (n > 12) ? 30 : $urandom_range(40, 120);
         for (int j = 0; j < nq && items_sent < ITEM_GOAL; j++) begin
            if (phase == 4 && j == 20) drain();
            if ($urandom_range(0, 9) == 0) begin
               send_item(OP_LOAD, $urandom_range(0, 255), $urandom & 32'h7FFF_FFFF,
                         random_vals(), 0, 0, z);
               continue;
            end
            case ($urandom_range(0, 19))
               0, 1, 2: q = longint'(signed'($urandom));
               3, 4, 5: q = kf_time[$urandom_range(0, last)] + $urandom_range(0, 2) - 1;
               default: q = longint'($urandom_range(0, lt + step)) - $urandom_range(0, step);
            endcase
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            send_item(OP_QUERY, 0, 0, '0, q[31:0], 0, z);
         end
         calm = 0;
      end

      drain();
      repeat (100) @(posedge clock);
      $display("tb: %0d items sent in %0d settings, %0d queries, %0d poses checked, %0d errors",
               items_sent, phase + 4, queries_sent, poses_seen, errors);
      if (errors == 0 && pose_queue.size() == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
